// ===== rtl/twcs_pkg.sv =====
// Shared types, codes and timing helpers of the timed wash cycle sequencer.
package twcs_pkg;

	localparam int TIMER_BITS = 24;

	localparam int unsigned MS_PER_MIN = 60000;
	localparam int unsigned MS_PER_DRY_STEP = 10 * MS_PER_MIN;
	localparam logic [7:0] DRY_CODE_MAX = 8'd9;
	localparam logic [7:0] MINS_MAX = 8'd255;

	// Minutes are found as ceil(t / 60000): the numerator is shifted right by five
	// and then divided by 1875 through an exact reciprocal multiply.
	localparam int NUMER_SHIFT = 5;
	localparam int NUMER_W = TIMER_BITS + 1 - NUMER_SHIFT;
	localparam longint unsigned MIN_DIV = MS_PER_MIN >> NUMER_SHIFT;
	localparam int RECIP_SHIFT = NUMER_W + 11;
	localparam int RECIP_W = RECIP_SHIFT - 10;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + MIN_DIV - 64'd1) / MIN_DIV;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
	localparam int PROD_W = NUMER_W + RECIP_W;
	localparam int QUOT_W = PROD_W - RECIP_SHIFT;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_DRAIN_TIME = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READY_LEVEL = 1'd1;
	localparam logic [23:0] DRAIN_TIME_RESET = 24'd60000;
	localparam logic [7:0] READY_LEVEL_RESET = 8'd1;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_COMMAND = 2'd1;
	localparam logic [1:0] ACT_LINK = 2'd2;
	localparam logic [1:0] ACT_LEVEL = 2'd3;

	localparam logic [7:0] CMD_OFF = 8'hB0;
	localparam logic [7:0] CMD_STANDBY = 8'hB1;
	localparam logic [7:0] CMD_AUTO = 8'hB3;
	localparam logic [7:0] CMD_FORCE_DRAIN = 8'hB4;
	localparam logic [7:0] CMD_CLEAN = 8'hB5;
	localparam logic [7:0] CMD_CLEAR = 8'hB6;
	localparam logic [7:0] CMD_DRY = 8'hB7;
	localparam logic [7:0] CMD_SELF_CHECK = 8'hB8;

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_DRAIN1 = 4'd1;
	localparam logic [3:0] PH_HOT1 = 4'd2;
	localparam logic [3:0] PH_CLEAN = 4'd3;
	localparam logic [3:0] PH_DRAIN2 = 4'd4;
	localparam logic [3:0] PH_HOT2 = 4'd5;
	localparam logic [3:0] PH_DRAIN3 = 4'd6;
	localparam logic [3:0] PH_DRY = 4'd7;
	localparam logic [3:0] PH_FORCE = 4'd8;
	localparam logic [3:0] PH_S_CLEAN = 4'd9;
	localparam logic [3:0] PH_S_CLEAR = 4'd10;
	localparam logic [3:0] PH_S_DRY = 4'd11;

	localparam logic [2:0] MAIN_POWER_ON = 3'd0;
	localparam logic [2:0] MAIN_OFF = 3'd1;
	localparam logic [2:0] MAIN_STANDBY = 3'd2;
	localparam logic [2:0] MAIN_RUNNING = 3'd3;
	localparam logic [2:0] MAIN_SELF_CHECK = 3'd4;

	localparam logic [3:0] SUB_IDLE = 4'd0;
	localparam logic [3:0] SUB_DRAIN1 = 4'd1;
	localparam logic [3:0] SUB_CLEAR = 4'd2;
	localparam logic [3:0] SUB_CLEAN = 4'd3;
	localparam logic [3:0] SUB_DRAIN2 = 4'd4;
	localparam logic [3:0] SUB_DRY = 4'd5;
	localparam logic [3:0] SUB_FORCE = 4'd6;
	localparam logic [3:0] SUB_S_CLEAN = 4'd7;
	localparam logic [3:0] SUB_S_CLEAR = 4'd8;
	localparam logic [3:0] SUB_S_DRY = 4'd9;

	localparam logic [2:0] LT_OFF = 3'd0;
	localparam logic [2:0] LT_DRAIN = 3'd1;
	localparam logic [2:0] LT_SPRAY = 3'd2;
	localparam logic [2:0] LT_DRY = 3'd3;
	localparam logic [2:0] LT_SELF_CHECK = 3'd4;

	localparam logic [5:0] EN_HEAT = 6'h01;
	localparam logic [5:0] EN_FAN = 6'h02;
	localparam logic [5:0] EN_IN = 6'h04;
	localparam logic [5:0] EN_OUT = 6'h08;
	localparam logic [5:0] EN_PUMP = 6'h10;
	localparam logic [5:0] EN_MOTOR = 6'h20;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] command_code;
		logic [7:0] cleaner_minutes;
		logic [7:0] rinse_minutes;
		logic [7:0] dry_code;
		logic       link_connected;
		logic [7:0] level_value;
	} item_t;

	typedef struct packed {
		logic [2:0] station_mode;
		logic [3:0] cycle_step;
		logic       heater_on;
		logic       fan_on;
		logic       inlet_on;
		logic       outlet_on;
		logic       cleaner_pump_on;
		logic       spray_motor_on;
		logic       circulation_request;
		logic [2:0] light_scene;
		logic [7:0] minutes_left;
		logic       link_up;
	} result_t;

	// Status snapshot handed from the sequencer to the minutes stage.
	typedef struct packed {
		logic [2:0]         station_mode;
		logic [3:0]         cycle_step;
		logic [5:0]         enables;
		logic               circ;
		logic [2:0]         light;
		logic               link;
		logic               has_timer;
		logic [NUMER_W-1:0] numer;
	} snap_t;

	function automatic logic [TIMER_BITS-1:0] min_ms(input logic [7:0] m);
		min_ms = TIMER_BITS'(32'(m) * MS_PER_MIN);
	endfunction

	function automatic logic [TIMER_BITS-1:0] dry_ms(input logic [7:0] c);
		logic [7:0] cc;
		cc = (c > DRY_CODE_MAX) ? DRY_CODE_MAX : c;
		dry_ms = TIMER_BITS'(32'(cc) * MS_PER_DRY_STEP);
	endfunction

endpackage

// ===== rtl/twcs_core.sv =====
// Sequencer state, configuration registers and next-state logic with the snapshot register.
module twcs_core
	import twcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  item_t                 item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output snap_t                 snap_s1
);

	typedef struct packed {
		logic [3:0]            phase;
		logic [2:0]            main;
		logic [3:0]            sub;
		logic [TIMER_BITS-1:0] tleft;
		logic                  trun;
		logic [7:0]            cmin;
		logic [7:0]            rmin;
		logic [7:0]            dcode;
		logic [5:0]            en;
		logic                  circ;
		logic [2:0]            light;
		logic                  linked;
		logic [7:0]            level;
	} st_t;

	localparam st_t CORE_RESET = '{phase: PH_IDLE, main: MAIN_POWER_ON, sub: SUB_IDLE,
		tleft: '0, trun: 1'b0, cmin: '0, rmin: '0, dcode: '0, en: '0, circ: 1'b0,
		light: LT_OFF, linked: 1'b0, level: '0};

	st_t                   cur_q;
	st_t                   nx;
	logic [23:0]           drain_q;
	logic [7:0]            ready_q;
	logic [TIMER_BITS-1:0] drain_ms;
	logic [TIMER_BITS-1:0] t;
	logic [TIMER_BITS:0]   numer_full;
	snap_t                 snap;

	function automatic st_t f_all_off(input st_t s);
		st_t r;
		r = s;
		r.en = '0;
		r.light = LT_OFF;
		r.circ = 1'b0;
		return r;
	endfunction

	function automatic st_t f_standby(input st_t s);
		st_t r;
		r = f_all_off(s);
		r.phase = PH_IDLE;
		r.trun = 1'b0;
		r.tleft = '0;
		r.main = MAIN_STANDBY;
		r.sub = SUB_IDLE;
		return r;
	endfunction

	function automatic st_t f_start(input st_t s, input logic [3:0] ph, input logic [3:0] sb,
			input logic [TIMER_BITS-1:0] ms);
		st_t r;
		r = s;
		r.phase = ph;
		r.main = MAIN_RUNNING;
		r.sub = sb;
		r.tleft = ms;
		r.trun = 1'b1;
		return r;
	endfunction

	function automatic st_t f_drain(input st_t s);
		st_t r;
		r = s;
		r.en = (s.en & EN_FAN) | EN_OUT;
		r.circ = 1'b0;
		r.light = LT_DRAIN;
		return r;
	endfunction

	function automatic st_t f_spray(input st_t s, input logic cleaner);
		st_t r;
		r = s;
		r.en = (s.en & EN_FAN) | EN_IN | EN_HEAT | EN_MOTOR | (cleaner ? EN_PUMP : 6'h00);
		r.light = LT_SPRAY;
		return r;
	endfunction

	function automatic st_t f_dry(input st_t s);
		st_t r;
		r = s;
		r.en = EN_FAN;
		r.circ = 1'b0;
		r.light = LT_DRY;
		return r;
	endfunction

	assign drain_ms = TIMER_BITS'(drain_q);

	always_comb begin
		nx = cur_q;
		t = cur_q.tleft;
		unique case (item.action)
			ACT_TICK: begin
				if (cur_q.trun) begin
					if (t != '0) begin
						t = t - TIMER_BITS'(1);
					end
					nx.tleft = t;
					if (t == '0) begin
						unique case (cur_q.phase)
							PH_DRAIN1: nx = f_start(f_spray(nx, 1'b0), PH_HOT1, SUB_CLEAR,
								min_ms(cur_q.rmin));
							PH_HOT1: begin
								nx = f_spray(nx, 1'b1);
								nx.circ = 1'b1;
								nx = f_start(nx, PH_CLEAN, SUB_CLEAN, min_ms(cur_q.cmin));
							end
							PH_CLEAN: nx = f_start(f_drain(nx), PH_DRAIN2, SUB_DRAIN1, drain_ms);
							PH_DRAIN2: nx = f_start(f_spray(nx, 1'b0), PH_HOT2, SUB_CLEAR,
								min_ms(cur_q.rmin));
							PH_HOT2: nx = f_start(f_drain(nx), PH_DRAIN3, SUB_DRAIN2, drain_ms);
							PH_DRAIN3: nx = f_start(f_dry(nx), PH_DRY, SUB_DRY,
								dry_ms(cur_q.dcode));
							default: nx = f_standby(nx);
						endcase
					end
				end
				if (nx.phase == PH_HOT2 && cur_q.level >= ready_q) begin
					nx.circ = 1'b1;
				end
			end
			ACT_COMMAND: begin
				nx.cmin = item.cleaner_minutes;
				nx.rmin = item.rinse_minutes;
				nx.dcode = item.dry_code;
				unique case (item.command_code)
					CMD_OFF: begin
						nx = f_standby(nx);
						nx.main = MAIN_OFF;
					end
					CMD_STANDBY: nx = f_standby(nx);
					CMD_AUTO: nx = f_start(f_drain(nx), PH_DRAIN1, SUB_DRAIN1, drain_ms);
					CMD_FORCE_DRAIN: nx = f_start(f_drain(nx), PH_FORCE, SUB_FORCE, drain_ms);
					CMD_CLEAN: nx = f_start(f_spray(nx, 1'b1), PH_S_CLEAN, SUB_S_CLEAN,
						min_ms(item.cleaner_minutes));
					CMD_CLEAR: nx = f_start(f_spray(nx, 1'b0), PH_S_CLEAR, SUB_S_CLEAR,
						min_ms(item.rinse_minutes));
					CMD_DRY: nx = f_start(f_dry(nx), PH_S_DRY, SUB_S_DRY,
						dry_ms(item.dry_code));
					CMD_SELF_CHECK: begin
						nx.main = MAIN_SELF_CHECK;
						nx.sub = SUB_IDLE;
						nx.light = LT_SELF_CHECK;
					end
					default: begin
					end
				endcase
			end
			ACT_LINK: begin
				nx.linked = item.link_connected;
				if (cur_q.linked && !item.link_connected && cur_q.circ) begin
					nx = f_standby(nx);
				end
			end
			ACT_LEVEL: nx.level = item.level_value;
		endcase
	end

	always_comb begin
		numer_full = {1'b0, nx.tleft} + (TIMER_BITS+1)'(MS_PER_MIN - 1);
		snap.station_mode = nx.main;
		snap.cycle_step = nx.sub;
		snap.enables = nx.en;
		snap.circ = nx.circ;
		snap.light = nx.light;
		snap.link = nx.linked;
		snap.has_timer = nx.trun && (nx.tleft != '0);
		snap.numer = numer_full[TIMER_BITS:NUMER_SHIFT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= CORE_RESET;
		end else if (accept) begin
			cur_q <= nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= DRAIN_TIME_RESET;
			ready_q <= READY_LEVEL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DRAIN_TIME: drain_q <= cfg_wdata;
				REG_READY_LEVEL: ready_q <= cfg_wdata[7:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			snap_s1 <= snap;
		end
	end

endmodule

// ===== rtl/twcs_minutes.sv =====
// Result register stage that converts the remaining time to whole minutes.
module twcs_minutes
	import twcs_pkg::*;
(
	input  logic    clk,
	input  logic    load,
	input  snap_t   snap_s1,
	output result_t result_s2
);

	logic [PROD_W-1:0] prod;
	logic [QUOT_W-1:0] quot;
	logic [7:0]        mins;
	result_t           res;

	always_comb begin
		prod = PROD_W'(snap_s1.numer) * PROD_W'(RECIP);
		quot = prod[PROD_W-1:RECIP_SHIFT];
		if (!snap_s1.has_timer) begin
			mins = '0;
		end else if (quot > QUOT_W'(MINS_MAX)) begin
			mins = MINS_MAX;
		end else begin
			mins = quot[7:0];
		end
		res.station_mode = snap_s1.station_mode;
		res.cycle_step = snap_s1.cycle_step;
		res.heater_on = |(snap_s1.enables & EN_HEAT);
		res.fan_on = |(snap_s1.enables & EN_FAN);
		res.inlet_on = |(snap_s1.enables & EN_IN);
		res.outlet_on = |(snap_s1.enables & EN_OUT);
		res.cleaner_pump_on = |(snap_s1.enables & EN_PUMP);
		res.spray_motor_on = |(snap_s1.enables & EN_MOTOR);
		res.circulation_request = snap_s1.circ;
		res.light_scene = snap_s1.light;
		res.minutes_left = mins;
		res.link_up = snap_s1.link;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= res;
		end
	end

endmodule

// ===== rtl/timed_wash_cycle_sequencer.sv =====
// Top level of the timed wash cycle sequencer: handshake control and stage wiring.
//
// Usage: each beat on the item channel is a 1 ms tick, a command, a link change
// or a water level reading. Every accepted beat produces exactly one beat on the
// result channel carrying the full status after that beat was applied.
// The item beat updates the sequencer state at the edge where it is accepted and
// its status is captured in a snapshot register. The next stage converts the
// remaining time to minutes through a reciprocal multiply and registers the
// result. The result beat passes through the snapshot register and then the result
// register before it becomes valid, and a stalled receiver holds it there.
// Throughput is one beat per cycle while the receiver does not stall.
// The configuration port writes the drain time and the ready level; it must be
// written only while no beat is in flight.
// When the receiver stalls, the result register holds its beat and the snapshot
// stage still takes one more item; after that, item_ready drops until the
// result is taken. Reset clears the sequencer state, sets the drain time to 60000 ms and
// the ready level to 1, and empties both stages.
module timed_wash_cycle_sequencer
	import twcs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic  valid_s1;
	logic  valid_s2;
	logic  advance;
	logic  accept;
	snap_t snap_s1;

	assign advance = !valid_s2 || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign accept = item_valid && item_ready;
	assign result_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	twcs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.snap_s1   (snap_s1)
	);

	twcs_minutes u_minutes (
		.clk       (clk),
		.load      (advance && valid_s1),
		.snap_s1   (snap_s1),
		.result_s2 (result)
	);

endmodule

// ===== rtl/twcs_checker.sv =====
// Port-level assertions of the timed wash cycle sequencer and their bind.
module twcs_checker
	import twcs_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result beat changed while stalled");

	a_timer_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.minutes_left != 8'd0 |->
		result.station_mode == MAIN_RUNNING || result.station_mode == MAIN_SELF_CHECK)
		else $error("remaining minutes shown outside a running cycle");

	a_off_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.station_mode == MAIN_OFF |->
		!result.heater_on && !result.fan_on && !result.inlet_on && !result.outlet_on &&
		!result.cleaner_pump_on && !result.spray_motor_on && !result.circulation_request &&
		result.light_scene == LT_OFF && result.minutes_left == 8'd0)
		else $error("an output is active while the station is off");

	a_circ_only_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.circulation_request |->
		result.station_mode == MAIN_RUNNING || result.station_mode == MAIN_SELF_CHECK)
		else $error("circulation requested outside a running cycle");

endmodule

bind timed_wash_cycle_sequencer twcs_checker u_twcs_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench of the timed wash cycle sequencer with a status predictor.
module testbench;
	import twcs_pkg::*;

	localparam logic [7:0] CMD_UNUSED = 8'hB2;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HOLD_CYCLES = 80;
	localparam int BLOCK_ITEMS = 470;

	class wash_scoreboard;
		logic [23:0] drain_ms;
		logic [7:0]  ready_lvl;
		logic [3:0]  phase;
		logic [2:0]  main_st;
		logic [3:0]  sub_st;
		logic [23:0] time_left;
		bit          timer_on;
		logic [7:0]  cleaner_min;
		logic [7:0]  rinse_min;
		logic [7:0]  dry_code;
		logic [5:0]  enables;
		bit          circ;
		logic [2:0]  light;
		bit          linked;
		logic [7:0]  level;
		result_t     expected_status[$];
		int          mismatches;
		int          results_seen;

		function void power_up();
			drain_ms = DRAIN_TIME_RESET;
			ready_lvl = READY_LEVEL_RESET;
			phase = PH_IDLE;
			main_st = MAIN_POWER_ON;
			sub_st = SUB_IDLE;
			time_left = '0;
			timer_on = 1'b0;
			cleaner_min = '0;
			rinse_min = '0;
			dry_code = '0;
			enables = '0;
			circ = 1'b0;
			light = LT_OFF;
			linked = 1'b0;
			level = '0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_DRAIN_TIME) begin
				drain_ms = data[23:0];
			end else if (idx == REG_READY_LEVEL) begin
				ready_lvl = data[7:0];
			end
		endfunction

		function logic [23:0] minutes_to_ms(logic [7:0] m);
			return 24'(32'(m) * MS_PER_MIN);
		endfunction

		function logic [23:0] dry_to_ms(logic [7:0] c);
			logic [7:0] k;
			k = (c > DRY_CODE_MAX) ? DRY_CODE_MAX : c;
			return 24'(32'(k) * 10 * MS_PER_MIN);
		endfunction

		function void go_standby();
			enables = '0;
			light = LT_OFF;
			circ = 1'b0;
			phase = PH_IDLE;
			timer_on = 1'b0;
			time_left = '0;
			main_st = MAIN_STANDBY;
			sub_st = SUB_IDLE;
		endfunction

		function void start_phase(logic [3:0] ph, logic [3:0] sub, logic [23:0] ms);
			phase = ph;
			main_st = MAIN_RUNNING;
			sub_st = sub;
			time_left = ms;
			timer_on = 1'b1;
		endfunction

		function void set_drain();
			enables = (enables & EN_FAN) | EN_OUT;
			circ = 1'b0;
			light = LT_DRAIN;
		endfunction

		function void set_spray(bit use_pump);
			enables = (enables & EN_FAN) | EN_IN | EN_HEAT | EN_MOTOR |
				(use_pump ? EN_PUMP : 6'b0);
			light = LT_SPRAY;
		endfunction

		function void set_dry();
			enables = EN_FAN;
			circ = 1'b0;
			light = LT_DRY;
		endfunction

		function void apply_item(item_t x);
			bit was_linked;
			int unsigned mins;
			result_t s;
			case (x.action)
				ACT_TICK: begin
					if (timer_on) begin
						if (time_left != 0)
							time_left--;
						if (time_left == 0) begin
							case (phase)
								PH_DRAIN1: begin
									set_spray(1'b0);
									start_phase(PH_HOT1, SUB_CLEAR, minutes_to_ms(rinse_min));
								end
								PH_HOT1: begin
									set_spray(1'b1);
									circ = 1'b1;
									start_phase(PH_CLEAN, SUB_CLEAN, minutes_to_ms(cleaner_min));
								end
								PH_CLEAN: begin
									set_drain();
									start_phase(PH_DRAIN2, SUB_DRAIN1, drain_ms);
								end
								PH_DRAIN2: begin
									set_spray(1'b0);
									start_phase(PH_HOT2, SUB_CLEAR, minutes_to_ms(rinse_min));
								end
								PH_HOT2: begin
									set_drain();
									start_phase(PH_DRAIN3, SUB_DRAIN2, drain_ms);
								end
								PH_DRAIN3: begin
									set_dry();
									start_phase(PH_DRY, SUB_DRY, dry_to_ms(dry_code));
								end
								default: go_standby();
							endcase
						end
					end
					if (phase == PH_HOT2 && level >= ready_lvl)
						circ = 1'b1;
				end
				ACT_COMMAND: begin
					cleaner_min = x.cleaner_minutes;
					rinse_min = x.rinse_minutes;
					dry_code = x.dry_code;
					case (x.command_code)
						CMD_OFF: begin
							go_standby();
							main_st = MAIN_OFF;
						end
						CMD_STANDBY: go_standby();
						CMD_AUTO: begin
							set_drain();
							start_phase(PH_DRAIN1, SUB_DRAIN1, drain_ms);
						end
						CMD_FORCE_DRAIN: begin
							set_drain();
							start_phase(PH_FORCE, SUB_FORCE, drain_ms);
						end
						CMD_CLEAN: begin
							set_spray(1'b1);
							start_phase(PH_S_CLEAN, SUB_S_CLEAN, minutes_to_ms(cleaner_min));
						end
						CMD_CLEAR: begin
							set_spray(1'b0);
							start_phase(PH_S_CLEAR, SUB_S_CLEAR, minutes_to_ms(rinse_min));
						end
						CMD_DRY: begin
							set_dry();
							start_phase(PH_S_DRY, SUB_S_DRY, dry_to_ms(dry_code));
						end
						CMD_SELF_CHECK: begin
							main_st = MAIN_SELF_CHECK;
							sub_st = SUB_IDLE;
							light = LT_SELF_CHECK;
						end
						default: ;
					endcase
				end
				ACT_LINK: begin
					was_linked = linked;
					linked = x.link_connected;
					if (was_linked && !linked && circ)
						go_standby();
				end
				default: level = x.level_value;
			endcase

			mins = 0;
			if (timer_on && time_left != 0) begin
				mins = (32'(time_left) + MS_PER_MIN - 1) / MS_PER_MIN;
				if (mins > MINS_MAX)
					mins = MINS_MAX;
			end
			s.station_mode = main_st;
			s.cycle_step = sub_st;
			s.heater_on = |(enables & EN_HEAT);
			s.fan_on = |(enables & EN_FAN);
			s.inlet_on = |(enables & EN_IN);
			s.outlet_on = |(enables & EN_OUT);
			s.cleaner_pump_on = |(enables & EN_PUMP);
			s.spray_motor_on = |(enables & EN_MOTOR);
			s.circulation_request = circ;
			s.light_scene = light;
			s.minutes_left = mins[7:0];
			s.link_up = linked;
			expected_status.push_back(s);
		endfunction

		task report_mismatch(string what, int unsigned got, int unsigned want);
			$display("mismatch on result %0d, %s: got %0d, expected %0d",
				results_seen, what, got, want);
			mismatches++;
		endtask

		task check_status(result_t got);
			result_t want;
			results_seen++;
			if (expected_status.size() == 0) begin
				report_mismatch("result beat with nothing pending", 1, 0);
				return;
			end
			want = expected_status.pop_front();
			if (got.station_mode !== want.station_mode)
				report_mismatch("station_mode", got.station_mode, want.station_mode);
			if (got.cycle_step !== want.cycle_step)
				report_mismatch("cycle_step", got.cycle_step, want.cycle_step);
			if (got.heater_on !== want.heater_on)
				report_mismatch("heater_on", got.heater_on, want.heater_on);
			if (got.fan_on !== want.fan_on)
				report_mismatch("fan_on", got.fan_on, want.fan_on);
			if (got.inlet_on !== want.inlet_on)
				report_mismatch("inlet_on", got.inlet_on, want.inlet_on);
			if (got.outlet_on !== want.outlet_on)
				report_mismatch("outlet_on", got.outlet_on, want.outlet_on);
			if (got.cleaner_pump_on !== want.cleaner_pump_on)
				report_mismatch("cleaner_pump_on", got.cleaner_pump_on, want.cleaner_pump_on);
			if (got.spray_motor_on !== want.spray_motor_on)
				report_mismatch("spray_motor_on", got.spray_motor_on, want.spray_motor_on);
			if (got.circulation_request !== want.circulation_request)
				report_mismatch("circulation_request", got.circulation_request,
					want.circulation_request);
			if (got.light_scene !== want.light_scene)
				report_mismatch("light_scene", got.light_scene, want.light_scene);
			if (got.minutes_left !== want.minutes_left)
				report_mismatch("minutes_left", got.minutes_left, want.minutes_left);
			if (got.link_up !== want.link_up)
				report_mismatch("link_up", got.link_up, want.link_up);
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	wash_scoreboard sb;
	bit sender_quiet = 1'b0;
	bit receiver_quiet = 1'b0;
	bit hold_request = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;

	timed_wash_cycle_sequencer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic item_t build_item(logic [1:0] act, logic [7:0] code = '0,
			logic [7:0] cl = '0, logic [7:0] ri = '0, logic [7:0] dry = '0,
			logic lnk = 1'b0, logic [7:0] lvl = '0);
		item_t x;
		x.action = act;
		x.command_code = code;
		x.cleaner_minutes = cl;
		x.rinse_minutes = ri;
		x.dry_code = dry;
		x.link_connected = lnk;
		x.level_value = lvl;
		return x;
	endfunction

	function automatic item_t rand_item();
		item_t x;
		int r;
		r = $urandom_range(0, 99);
		x.action = (r < 50) ? ACT_TICK : (r < 70) ? ACT_COMMAND : (r < 85) ? ACT_LINK : ACT_LEVEL;
		x.command_code = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) != 0) begin
			case ($urandom_range(0, 8))
				0: x.command_code = CMD_OFF;
				1: x.command_code = CMD_STANDBY;
				2: x.command_code = CMD_UNUSED;
				3: x.command_code = CMD_AUTO;
				4: x.command_code = CMD_FORCE_DRAIN;
				5: x.command_code = CMD_CLEAN;
				6: x.command_code = CMD_CLEAR;
				7: x.command_code = CMD_DRY;
				default: x.command_code = CMD_SELF_CHECK;
			endcase
		end
		x.cleaner_minutes = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(0, 255));
		x.rinse_minutes = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(0, 255));
		x.dry_code = ($urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(0, 255));
		x.link_connected = 1'($urandom_range(0, 1));
		x.level_value = 8'($urandom_range(0, 255));
		return x;
	endfunction

	task automatic send_item(item_t x);
		int gap;
		if ($urandom_range(0, 31) == 0)
			sender_quiet = !sender_quiet;
		gap = sender_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (!item_ready);
		sb.apply_item(x);
		items_sent++;
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		while (sb.expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(logic [23:0] drain, logic [7:0] ready);
		logic [CFG_DATA_W-1:0] rdata;
		rdata = CFG_DATA_W'($urandom);
		rdata[7:0] = ready;
		cfg_we <= 1'b1;
		cfg_index <= REG_DRAIN_TIME;
		cfg_wdata <= drain;
		@(posedge clk);
		sb.write_reg(REG_DRAIN_TIME, drain);
		cfg_index <= REG_READY_LEVEL;
		cfg_wdata <= rdata;
		@(posedge clk);
		sb.write_reg(REG_READY_LEVEL, rdata);
		cfg_we <= 1'b0;
	endtask

	// Auto clean with random content, followed by mostly ticks and some events.
	task automatic auto_run();
		item_t x;
		int r;
		x = rand_item();
		x.action = ACT_LINK;
		x.link_connected = 1'b1;
		if ($urandom_range(0, 3) != 0)
			send_item(x);
		x = rand_item();
		x.action = ACT_LEVEL;
		send_item(x);
		x = rand_item();
		x.action = ACT_COMMAND;
		x.command_code = CMD_AUTO;
		if ($urandom_range(0, 15) != 0) begin
			x.cleaner_minutes = '0;
			x.rinse_minutes = '0;
		end
		if ($urandom_range(0, 7) != 0)
			x.dry_code = '0;
		send_item(x);
		repeat ($urandom_range(10, 40)) begin
			x = rand_item();
			r = $urandom_range(0, 9);
			if (r < 7)
				x.action = ACT_TICK;
			else if (r == 7)
				x.action = ACT_LEVEL;
			else if (r == 8)
				x.action = ACT_LINK;
			send_item(x);
		end
	endtask

	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			if ($urandom_range(0, 31) == 0)
				receiver_quiet = !receiver_quiet;
			gap = receiver_quiet ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			sb.check_status(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int target;
		sb = new;
		sb.power_up();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_LEVEL, '0, '0, '0, '0, 1'b0, '1));
		send_item(build_item(ACT_LINK, '0, '0, '0, '0, 1'b1));
		send_item(build_item(ACT_LINK));
		send_item(build_item(ACT_COMMAND, '0, '1, '1, '1));
		send_item(build_item(ACT_COMMAND, CMD_UNUSED));
		send_item(build_item(ACT_COMMAND, '1, '1, '1, '1, 1'b1, '1));
		send_item(build_item(ACT_COMMAND, CMD_SELF_CHECK));
		send_item(build_item(ACT_COMMAND, CMD_OFF));
		send_item(build_item(ACT_COMMAND, CMD_STANDBY));
		send_item(build_item(ACT_COMMAND, CMD_CLEAN));
		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_COMMAND, CMD_CLEAR, '0, 8'd1));
		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_COMMAND, CMD_SELF_CHECK));
		send_item(build_item(ACT_COMMAND, CMD_DRY, '0, '0, '1));
		send_item(build_item(ACT_COMMAND, CMD_FORCE_DRAIN));
		send_item(build_item(ACT_COMMAND, CMD_AUTO, '1, '1, '1));
		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_COMMAND, CMD_OFF));
		send_item(build_item(ACT_TICK));

		settle();
		configure('1, '1);
		send_item(build_item(ACT_COMMAND, CMD_AUTO));
		send_item(build_item(ACT_COMMAND, CMD_CLEAN, '1));
		send_item(build_item(ACT_COMMAND, CMD_OFF));

		settle();
		configure(24'd60001, 8'd128);
		send_item(build_item(ACT_COMMAND, CMD_FORCE_DRAIN));
		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_COMMAND, CMD_STANDBY));

		// A link drop while circulation runs in the cleaner spray aborts the cycle.
		settle();
		configure('0, '0);
		send_item(build_item(ACT_LINK, '0, '0, '0, '0, 1'b1));
		send_item(build_item(ACT_COMMAND, CMD_AUTO));
		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_TICK));
		send_item(build_item(ACT_LINK));

		for (int blk = 0; blk < 4; blk++) begin
			settle();
			configure(24'($urandom_range(0, 8)), 8'($urandom_range(0, 255)));
			if (blk == 0)
				hold_request = 1'b1;
			target = items_sent + BLOCK_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(0, 9) < 7)
					auto_run();
				else
					repeat ($urandom_range(1, 8)) send_item(rand_item());
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_status.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/twcs_pkg.sv
rtl/twcs_core.sv
rtl/twcs_minutes.sv
rtl/timed_wash_cycle_sequencer.sv
rtl/twcs_checker.sv
dv/testbench.sv
